// ===== rtl/vadhs_pkg.sv =====
package vadhs_pkg;

   // Q1.15 fixed point, 32768 is 1.0
   localparam int LEVEL_W = 16;
   localparam int PROB_W = 17;
   localparam int RUN_W = 8;
   localparam int HANG_W = 12;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_INDEX_W = 3;

   localparam logic [LEVEL_W-1:0] ONE_Q15 = 16'd32768;
   localparam logic [RUN_W-1:0] RUN_MAX = 8'd255;

   // register reset values
   localparam logic [LEVEL_W-1:0] ALPHA_RST = 16'd16384;
   localparam logic [LEVEL_W-1:0] START_LEVEL_RST = 16'd16384;
   localparam logic [LEVEL_W-1:0] END_LEVEL_RST = 16'd8192;
   localparam logic [RUN_W-1:0] START_RUN_RST = 8'd3;
   localparam logic [RUN_W-1:0] END_RUN_RST = 8'd3;
   localparam logic [HANG_W-1:0] HANG_LEN_RST = 12'd30;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_SMOOTHING_ALPHA = 3'd0,
      REG_START_LEVEL = 3'd1,
      REG_END_LEVEL = 3'd2,
      REG_START_RUN = 3'd3,
      REG_END_RUN = 3'd4,
      REG_HANGOVER_LENGTH = 3'd5
   } csr_index_type;

endpackage

// ===== rtl/vadhs_ifs.sv =====
// request channel: one raw probability per beat
interface vadhs_req_if;
   logic valid;
   logic ready;
   logic signed [vadhs_pkg::PROB_W-1:0] probability;

   modport source (output valid, output probability, input ready);
   modport sink (input valid, input probability, output ready);
endinterface

// response channel: one decision per beat
interface vadhs_rsp_if;
   logic valid;
   logic ready;
   logic speaking;
   logic speech_started;
   logic speech_ended;
   logic [vadhs_pkg::LEVEL_W-1:0] smoothed_level;

   modport source (output valid, output speaking, output speech_started,
                   output speech_ended, output smoothed_level, input ready);
   modport sink (input valid, input speaking, input speech_started,
                 input speech_ended, input smoothed_level, output ready);
endinterface

// ===== rtl/vad_hangover_state_machine_top.sv =====
// Channel    Dir  Payload                                              Beat
// req_chan   in   probability (s17, Q2.15)                             one frame
// rsp_chan   out  speaking, speech_started, speech_ended, smoothed_level  one result
// csr_*      in   csr_we, csr_index (3b), csr_wdata (16b)              one register write
//
// One frame per cycle sustained while rsp is ready; a frame passes through the input
// register, then the result register, from req beat to rsp beat.
// The smoothing update and the counter decisions are combinational around the
// state registers: one 17x17 signed multiply, an add, and threshold compares.
// Synchronous active-high reset restores register defaults and clears the frame state.
// A stalled rsp holds the result register; the input register still takes a new
// beat whenever the result register can move.
module vad_hangover_state_machine_top (
   input  logic clock,
   input  logic reset,
   vadhs_req_if.sink req_chan,
   vadhs_rsp_if.source rsp_chan,
   input  logic csr_we,
   input  logic [vadhs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [vadhs_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int LW = vadhs_pkg::LEVEL_W;
   localparam int RW = vadhs_pkg::RUN_W;
   localparam int HW = vadhs_pkg::HANG_W;

   // configuration registers
   logic [LW-1:0] alpha_ff, start_level_ff, end_level_ff;
   logic [RW-1:0] start_run_ff, end_run_ff;
   logic [HW-1:0] hang_len_ff;

   // input stage
   logic in_valid_ff;
   logic [LW-1:0] prob_ff, prob_in;

   // frame state
   logic [LW-1:0] ema_ff, ema_in;
   logic speech_ff, speech_in;
   logic [RW-1:0] start_cnt_ff, start_cnt_in;
   logic [RW-1:0] end_cnt_ff, end_cnt_in;
   logic [HW-1:0] hang_cnt_ff, hang_cnt_in;

   // result register
   logic out_valid_ff;
   logic speaking_ff, started_ff, ended_ff;
   logic [LW-1:0] level_ff;

   logic advance;
   logic req_beat;

   // handshake: result register moves when empty or taken
   assign advance = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_beat = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.speaking = speaking_ff;
   assign rsp_chan.speech_started = started_ff;
   assign rsp_chan.speech_ended = ended_ff;
   assign rsp_chan.smoothed_level = level_ff;

   // clamp the raw probability to 0..1.0
   always_comb begin
      if (req_chan.probability[vadhs_pkg::PROB_W-1]) begin
         prob_in = '0;
      end else if (req_chan.probability[LW-1:0] > vadhs_pkg::ONE_Q15) begin
         prob_in = vadhs_pkg::ONE_Q15;
      end else begin
         prob_in = req_chan.probability[LW-1:0];
      end
   end

   // configuration writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= vadhs_pkg::ALPHA_RST;
         start_level_ff <= vadhs_pkg::START_LEVEL_RST;
         end_level_ff <= vadhs_pkg::END_LEVEL_RST;
         start_run_ff <= vadhs_pkg::START_RUN_RST;
         end_run_ff <= vadhs_pkg::END_RUN_RST;
         hang_len_ff <= vadhs_pkg::HANG_LEN_RST;
      end else if (csr_we) begin
         case (csr_index)
            vadhs_pkg::REG_SMOOTHING_ALPHA: alpha_ff <= csr_wdata[LW-1:0];
            vadhs_pkg::REG_START_LEVEL: start_level_ff <= csr_wdata[LW-1:0];
            vadhs_pkg::REG_END_LEVEL: end_level_ff <= csr_wdata[LW-1:0];
            vadhs_pkg::REG_START_RUN: start_run_ff <= csr_wdata[RW-1:0];
            vadhs_pkg::REG_END_RUN: end_run_ff <= csr_wdata[RW-1:0];
            vadhs_pkg::REG_HANGOVER_LENGTH: hang_len_ff <= csr_wdata[HW-1:0];
            default: ;
         endcase
      end
   end

   // smoothing: ema + floor(alpha * (p - ema) / 2^15)
   logic [LW-1:0] alpha_eff;
   logic signed [LW:0] alpha_s, diff_s;
   logic signed [2*LW+1:0] prod_s;
   logic signed [2*LW+1:0] step_s;
   logic signed [LW+1:0] sum_s;

   always_comb begin
      alpha_eff = (alpha_ff > vadhs_pkg::ONE_Q15) ? vadhs_pkg::ONE_Q15 : alpha_ff;
      alpha_s = $signed({1'b0, alpha_eff});
      diff_s = $signed({1'b0, prob_ff}) - $signed({1'b0, ema_ff});
      prod_s = alpha_s * diff_s;
      step_s = prod_s >>> 15;
      sum_s = $signed({2'b00, ema_ff}) + step_s[LW+1:0];
   end

   // run counters and hangover
   logic [RW-1:0] start_need, end_need;
   logic [HW-1:0] hang_load;

   always_comb begin
      start_need = (start_run_ff == '0) ? RW'(1) : start_run_ff;
      end_need = (end_run_ff == '0) ? RW'(1) : end_run_ff;
      hang_load = (hang_len_ff == '0) ? HW'(1) : hang_len_ff;

      ema_in = sum_s[LW-1:0];
      speech_in = speech_ff;
      start_cnt_in = start_cnt_ff;
      end_cnt_in = end_cnt_ff;
      hang_cnt_in = hang_cnt_ff;

      if (!speech_ff) begin
         if (ema_in >= start_level_ff) begin
            start_cnt_in = (start_cnt_ff == vadhs_pkg::RUN_MAX) ?
                           vadhs_pkg::RUN_MAX : start_cnt_ff + RW'(1);
         end else begin
            start_cnt_in = '0;
         end
         if (start_cnt_in >= start_need) begin
            speech_in = 1'b1;
            start_cnt_in = '0;
            end_cnt_in = '0;
            hang_cnt_in = '0;
         end
      end else begin
         if (ema_in < end_level_ff) begin
            end_cnt_in = (end_cnt_ff == vadhs_pkg::RUN_MAX) ?
                         vadhs_pkg::RUN_MAX : end_cnt_ff + RW'(1);
         end else begin
            end_cnt_in = '0;
            hang_cnt_in = '0;
         end
         if (end_cnt_in >= end_need) begin
            if (hang_cnt_in == '0) begin
               hang_cnt_in = hang_load;
            end else begin
               hang_cnt_in = hang_cnt_in - HW'(1);
            end
            if (hang_cnt_in == '0) begin
               speech_in = 1'b0;
               end_cnt_in = '0;
            end
         end
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         ema_ff <= '0;
         speech_ff <= 1'b0;
         start_cnt_ff <= '0;
         end_cnt_ff <= '0;
         hang_cnt_ff <= '0;
      end else begin
         if (req_chan.ready) begin
            in_valid_ff <= req_chan.valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            ema_ff <= ema_in;
            speech_ff <= speech_in;
            start_cnt_ff <= start_cnt_in;
            end_cnt_ff <= end_cnt_in;
            hang_cnt_ff <= hang_cnt_in;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_beat) begin
         prob_ff <= prob_in;
      end
      if (advance) begin
         speaking_ff <= speech_in;
         started_ff <= !speech_ff && speech_in;
         ended_ff <= speech_ff && !speech_in;
         level_ff <= ema_in;
      end
   end

endmodule
